// ----- design/sha512_pkg.sv -----
// Shared types and constants of the SHA-512 hash engine.
package sha512_pkg;

  typedef logic [63:0] word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic put_byte;      // write one message byte into the block
    logic put_pad;       // write the terminator byte at the fill position
    logic put_len;       // write the bit length into the last two words
    logic comp_start;    // load schedule and working variables
    logic comp_round;    // run one round
    logic comp_finish;   // fold working variables into the chaining hash
    logic hash_reset;    // restore initial hash, clear count and fill
    logic [2:0] out_sel; // digest word to present
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic block_full;   // fill count at 127, so the next byte fills the block
    logic pad_overflow; // length field does not fit after the terminator
    logic last_round;   // round counter at 79
  } stat_t;

  localparam int unsigned Rounds = 80;

  localparam word_t InitHash [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam word_t RoundConst [Rounds] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

endpackage

// ----- design/sha512_if.sv -----
// Valid/ready channels of the SHA-512 hash engine.
interface sha512_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       byte_valid;
  logic       end_of_message;
  modport source (output valid, byte_value, byte_valid, end_of_message, input ready);
  modport sink (input valid, byte_value, byte_valid, end_of_message, output ready);
endinterface

interface sha512_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic [2:0]  word_pos;
  logic        last_word;
  modport source (output valid, digest_word, word_pos, last_word, input ready);
  modport sink (input valid, digest_word, word_pos, last_word, output ready);
endinterface

// ----- design/sha512_datapath.sv -----
// Block buffer, length counter, round unit and chaining hash of SHA-512.
module sha512_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          byte_i,
  input  sha512_pkg::ctrl_t   ctrl_i,
  output sha512_pkg::stat_t   stat_o,
  output sha512_pkg::word_t   digest_o
);
  import sha512_pkg::*;

  word_t       block_q [16];
  logic [6:0]  fill_q;
  logic [127:0] len_q;
  word_t       hash_q [8];
  word_t       var_q [8];
  word_t       win_q [16];
  logic [6:0]  rnd_q;

  word_t w_new, w_cur, t1, t2, s0, s1, pad_byte;
  logic [3:0] widx;
  logic [5:0] sh;

  // Message schedule word and round terms for the current round, byte position in the block
  always_comb begin
    s0 = rotr(win_q[1], 1) ^ rotr(win_q[1], 8) ^ (win_q[1] >> 7);
    s1 = rotr(win_q[14], 19) ^ rotr(win_q[14], 61) ^ (win_q[14] >> 6);
    w_new = s1 + win_q[9] + s0 + win_q[0];
    w_cur = (rnd_q < 7'd16) ? win_q[0] : w_new;
    t1 = var_q[7] + (rotr(var_q[4], 14) ^ rotr(var_q[4], 18) ^ rotr(var_q[4], 41))
       + ((var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6])) + RoundConst[rnd_q] + w_cur;
    t2 = (rotr(var_q[0], 28) ^ rotr(var_q[0], 34) ^ rotr(var_q[0], 39))
       + ((var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]));
    widx = fill_q[6:3];
    sh = {~fill_q[2:0], 3'b000};
    pad_byte = ctrl_i.put_pad ? 64'h80 : {56'd0, byte_i};
  end

  assign stat_o.block_full = (fill_q == 7'd127);
  assign stat_o.pad_overflow = (fill_q > 7'd111);
  assign stat_o.last_round = (rnd_q == 7'(Rounds - 1));
  assign digest_o = hash_q[ctrl_i.out_sel];

  // Window shifts by one word per round, oldest word at index 0; working variables update per round
  always_ff @(posedge clk_i) begin
    if (ctrl_i.comp_start) begin
      for (int i = 0; i < 16; i++) win_q[i] <= block_q[i];
      for (int i = 0; i < 8; i++) var_q[i] <= hash_q[i];
    end else if (ctrl_i.comp_round) begin
      for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
      win_q[15] <= w_cur;
      var_q[7] <= var_q[6];
      var_q[6] <= var_q[5];
      var_q[5] <= var_q[4];
      var_q[4] <= var_q[3] + t1;
      var_q[3] <= var_q[2];
      var_q[2] <= var_q[1];
      var_q[1] <= var_q[0];
      var_q[0] <= t1 + t2;
    end
  end

  // Block buffer, counters and chaining hash
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) block_q[i] <= '0;
      for (int i = 0; i < 8; i++) hash_q[i] <= InitHash[i];
      fill_q <= '0;
      len_q  <= '0;
      rnd_q  <= '0;
    end else begin
      if (ctrl_i.put_byte || ctrl_i.put_pad) begin
        block_q[widx] <= block_q[widx] | (pad_byte << sh);
        fill_q <= fill_q + 7'd1;
      end
      if (ctrl_i.put_byte) len_q <= len_q + 128'd8;
      if (ctrl_i.put_len) begin
        block_q[14] <= len_q[127:64];
        block_q[15] <= len_q[63:0];
      end
      if (ctrl_i.comp_start) begin
        rnd_q <= '0;
        for (int i = 0; i < 16; i++) block_q[i] <= '0;
      end
      // counter returns to zero after the last round
      if (ctrl_i.comp_round) rnd_q <= stat_o.last_round ? 7'd0 : rnd_q + 7'd1;
      if (ctrl_i.comp_finish) begin
        for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + var_q[i];
      end
      if (ctrl_i.hash_reset) begin
        for (int i = 0; i < 8; i++) hash_q[i] <= InitHash[i];
        fill_q <= '0;
        len_q  <= '0;
      end
    end
  end

`ifndef SYNTH
  a_round_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rnd_q < 7'(Rounds)) else $error("round counter beyond last round");
  a_pad_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_i.put_byte && ctrl_i.put_pad)) else $error("byte and pad together");
  a_fill_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.put_byte |=> len_q[2:0] == 3'd0) else $error("bit count not byte aligned");
`endif
endmodule

// ----- design/sha512_ctrl.sv -----
// Controller of the SHA-512 hash engine: item intake, padding, compression sequencing and output.
module sha512_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              byte_valid_i,
  input  logic              eom_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        out_index_o,
  output logic              out_last_o,
  output sha512_pkg::ctrl_t ctrl_o,
  input  sha512_pkg::stat_t stat_i
);
  import sha512_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_START, S_ROUND, S_FOLD, S_OUT
  } state_e;

  state_e     state_q;
  logic       final_q;  // compression is the last of the message
  logic       eom_q;    // finish pending after a full-block compression
  logic [2:0] idx_q;
  logic       acc;
  logic       ctrl_len_pending_q;  // length goes into the block after an overflow pad

  assign in_ready_o = (state_q == S_IDLE);
  assign acc = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == S_OUT);
  assign out_index_o = idx_q;
  assign out_last_o = (idx_q == 3'd7);

  // Command decode
  always_comb begin
    ctrl_o = '0;
    ctrl_o.out_sel = idx_q;
    ctrl_o.put_byte = acc && byte_valid_i;
    ctrl_o.put_pad = (state_q == S_PAD);
    // length fits after the terminator, or goes into the fresh block after overflow
    ctrl_o.put_len = ((state_q == S_PAD) && !stat_i.pad_overflow)
                   || ((state_q == S_FOLD) && ctrl_len_pending_q);
    ctrl_o.comp_start = (state_q == S_START);
    ctrl_o.comp_round = (state_q == S_ROUND);
    ctrl_o.comp_finish = (state_q == S_FOLD);
    ctrl_o.hash_reset = (state_q == S_OUT) && out_ready_i && out_last_o;
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      final_q <= 1'b0;
      eom_q   <= 1'b0;
      idx_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (acc) begin
            eom_q <= eom_i;
            final_q <= 1'b0;
            if (byte_valid_i && stat_i.block_full) state_q <= S_START;
            else if (eom_i) state_q <= S_PAD;
          end
        end
        S_PAD: begin
          // length fits in this block unless overflow; then a second pass
          final_q <= !stat_i.pad_overflow;
          state_q <= S_START;
          eom_q <= 1'b0;
        end
        S_START: state_q <= S_ROUND;
        S_ROUND: if (stat_i.last_round) state_q <= S_FOLD;
        S_FOLD: begin
          if (final_q) begin
            state_q <= S_OUT;
            idx_q <= '0;
          end else if (eom_q) begin
            state_q <= S_PAD;
          end else if (ctrl_len_pending_q) begin
            state_q <= S_START;
            final_q <= 1'b1;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_OUT: begin
          if (out_ready_i) begin
            idx_q <= idx_q + 3'd1;
            if (out_last_o) state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // After an overflowing pad block, the length goes into the fresh block
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ctrl_len_pending_q <= 1'b0;
    else if (state_q == S_PAD) ctrl_len_pending_q <= stat_i.pad_overflow;
    else if (state_q == S_FOLD) ctrl_len_pending_q <= 1'b0;
  end

`ifndef SYNTH
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("intake open during output");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_last_o |=> state_q == S_IDLE)
    else $error("no return to idle after last word");
  a_pad_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PAD |=> state_q == S_START) else $error("pad not followed by start");
`endif
endmodule

// ----- design/sha512_hash_engine_top.sv -----
// Top level of the SHA-512 hash engine.
// A byte that fills a block holds intake during the load, the 80 rounds and the fold.
// A finishing item runs one or two compressions before the first digest word, then 8 words.
// Throughput: one byte per cycle, none in padding, compression (one round unit) or output.
// Reset: asynchronous active low; restores initial hash, clears the block and bit count.
module sha512_hash_engine_top (
  input  logic clk_i,
  input  logic rst_ni,
  sha512_in_if.sink    in_if,
  sha512_out_if.source out_if
);
  import sha512_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  word_t digest;

  sha512_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .byte_valid_i(in_if.byte_valid),
    .eom_i       (in_if.end_of_message),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_index_o (out_if.word_pos),
    .out_last_o  (out_if.last_word),
    .ctrl_o      (ctrl),
    .stat_i      (stat)
  );

  sha512_datapath u_dp (
    .clk_i, .rst_ni,
    .byte_i  (in_if.byte_value),
    .ctrl_i  (ctrl),
    .stat_o  (stat),
    .digest_o(digest)
  );

  assign out_if.digest_word = digest;
endmodule

// ----- tb/sha512_hash_engine_top_tb.sv -----
// Self-checking testbench of the SHA-512 hash engine with its own digest predictor.
module sha512_hash_engine_top_tb;
  import sha512_pkg::*;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  word_pos;
    logic        last_word;
  } digest_item_t;

  localparam int unsigned MaxCycles = 2_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sha512_in_if  in_ch ();
  sha512_out_if out_ch ();

  sha512_hash_engine_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_ch.sink),
    .out_if (out_ch.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state
  word_t        msg_block [16];
  logic [7:0]   msg_fill;
  word_t        chain [8];
  logic [127:0] msg_bits;
  digest_item_t digest_q [$];

  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  bit           hold_recv = 1'b0;
  int unsigned  mismatches = 0;
  int unsigned  cycles = 0;

  function automatic word_t ror(word_t x, int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

  // One 80-round compression of msg_block into chain, then clear the block.
  task automatic compress_block();
    word_t w [16];
    word_t v [8];
    word_t t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) w[i] = msg_block[i];
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int t = 0; t < 80; t++) begin
      if (t >= 16) begin
        s0 = ror(w[(t-15)&15], 1) ^ ror(w[(t-15)&15], 8) ^ (w[(t-15)&15] >> 7);
        s1 = ror(w[(t-2)&15], 19) ^ ror(w[(t-2)&15], 61) ^ (w[(t-2)&15] >> 6);
        w[t&15] = s1 + w[(t-7)&15] + s0 + w[t&15];
      end
      t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[t] + w[t&15];
      t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
    for (int i = 0; i < 16; i++) msg_block[i] = '0;
  endtask

  task automatic place_byte(int unsigned pos, logic [7:0] b);
    msg_block[pos/8][(7 - pos%8)*8 +: 8] = b;
  endtask

  task automatic restart_hash();
    for (int i = 0; i < 8; i++) chain[i] = InitHash[i];
    for (int i = 0; i < 16; i++) msg_block[i] = '0;
    msg_fill = '0;
    msg_bits = '0;
  endtask

  // Update the predictor with one accepted item; queue digest words on finish.
  task automatic predict_digest(logic [7:0] b, logic bv, logic eom);
    digest_item_t d;
    if (bv) begin
      place_byte(msg_fill, b);
      msg_fill++;
      msg_bits += 128'd8;
      if (msg_fill == 8'd128) begin
        compress_block();
        msg_fill = '0;
      end
    end
    if (eom) begin
      place_byte(msg_fill, 8'h80);
      if (128 - (msg_fill + 1) < 16) compress_block();
      msg_block[14] = msg_bits[127:64];
      msg_block[15] = msg_bits[63:0];
      compress_block();
      for (int i = 0; i < 8; i++) begin
        d.digest_word = chain[i];
        d.word_pos = 3'(i);
        d.last_word = (i == 7);
        digest_q.push_back(d);
      end
      restart_hash();
    end
  endtask

  // Offer one item until it is accepted; valid stays up for a following item.
  task automatic send_item(logic [7:0] b, logic bv, logic eom);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid          <= 1'b1;
    in_ch.byte_value     <= b;
    in_ch.byte_valid     <= bv;
    in_ch.end_of_message <= eom;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_digest(b, bv, eom);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (digest_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_message(int unsigned len, bit pattern_ff);
    for (int unsigned i = 0; i < len; i++)
      send_item(pattern_ff ? 8'hff : 8'($urandom), 1'b1, i == len - 1);
  endtask

  // Receiver ready with random stalls and an optional long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !hold_recv && !(recv_stall_pct != 0 &&
                      $urandom_range(99) < recv_stall_pct);
    end
  end

  // Compare each accepted digest word with the oldest expectation
  always @(posedge clk_i) begin
    digest_item_t exp_d;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected digest word %h", out_ch.digest_word);
      end else begin
        exp_d = digest_q.pop_front();
        if (exp_d.digest_word !== out_ch.digest_word || exp_d.word_pos !== out_ch.word_pos
            || exp_d.last_word !== out_ch.last_word) begin
          mismatches++;
          if (mismatches <= 10)
            $display("digest mismatch: exp %h/%0d/%0b got %h/%0d/%0b", exp_d.digest_word,
                     exp_d.word_pos, exp_d.last_word, out_ch.digest_word,
                     out_ch.word_pos, out_ch.last_word);
        end
      end
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MaxCycles) begin
      $display("status: fail");
      $finish;
    end
  end

  // Directed: empty message, idle items, short messages, all-ones bytes
  task automatic test_directed();
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_message(3, 1'b1);
    send_item(8'h5a, 1'b0, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    wait_drained();
  endtask

  // Lengths at the padding and block edges
  task automatic test_block_edges();
    send_message(111, 1'b0);
    send_message(112, 1'b0);
    send_message(128, 1'b0);
    wait_drained();
  endtask

  // Random messages, mostly short, with idle items mixed in
  task automatic test_random(int unsigned n_items);
    int unsigned sent = 0;
    int unsigned len;
    while (sent < n_items) begin
      len = ($urandom_range(19) == 0) ? $urandom_range(140, 260) : $urandom_range(0, 20);
      for (int unsigned i = 0; i < len; i++) begin
        if ($urandom_range(7) == 0) send_item(8'($urandom), 1'b0, 1'b0);
        send_item(8'($urandom), 1'b1, 1'b0);
      end
      send_item(8'($urandom), 1'($urandom), 1'b1);
      sent += len + 1;
    end
  endtask

  // Long receiver hold-off while the sender keeps offering items
  task automatic test_backpressure();
    fork
      begin
        hold_recv = 1'b1;
        repeat (600) @(posedge clk_i);
        hold_recv = 1'b0;
      end
      begin
        send_message(5, 1'b0);
        send_message(9, 1'b0);
        send_message(2, 1'b0);
      end
    join
    wait_drained();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.byte_value = '0;
    in_ch.byte_valid = 1'b0;
    in_ch.end_of_message = 1'b0;
    restart_hash();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_block_edges();
    test_backpressure();
    test_random(10);
    send_idle_pct = 51;
    test_random(10);
    send_idle_pct = 0;
    recv_stall_pct = 51;
    test_random(10);
    send_idle_pct = 38;
    recv_stall_pct = 38;
    test_random(10);
    send_idle_pct = 0;
    recv_stall_pct = 0;

    wait_drained();
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && digest_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/sha512_pkg.sv
design/sha512_if.sv
design/sha512_datapath.sv
design/sha512_ctrl.sv
design/sha512_hash_engine_top.sv
tb/sha512_hash_engine_top_tb.sv
